// ----- rtl/pdc_pkg.sv -----
// Package for the packet deframer/checker: codes, header layout tables,
// the queue entry type and the byte-wise reflected CRC-32 step.
// No dependencies.
package pdc_pkg;

  localparam int HDR_BYTES     = 86;
  localparam int TRAILER_BYTES = 4;
  localparam int NUM_FIELDS    = 13;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_FIELD   = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_VERSION = 3'd2;
  localparam logic [2:0] ST_PAYLOAD = 3'd3;
  localparam logic [2:0] ST_LENGTH  = 3'd4;
  localparam logic [2:0] ST_CRC     = 3'd5;

  // field numbers with a side effect
  localparam logic [3:0] FLD_VERSION   = 4'd0;
  localparam logic [3:0] FLD_ATOMS     = 4'd4;
  localparam logic [3:0] FLD_PAYLOAD   = 4'd12;

  // config register indexes
  localparam int         CFG_IDX_W        = 1;
  localparam logic [0:0] CFG_EXP_VERSION  = 1'b0;
  localparam logic [0:0] CFG_RECORD_BYTES = 1'b1;

  // front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [7:0]  data;      // received byte
    logic        fin;       // last byte of the packet
    logic        crc_en;    // byte enters the CRC
    logic        trl_en;    // byte belongs to the trailer
    logic        emit;      // byte produces a field or payload result
    logic [1:0]  kind;
    logic [3:0]  field_idx;
    logic [63:0] value;     // on fin: {atom_total, declared_payload}
    logic        short_pkt;
    logic        ver_bad;
    logic        len_bad;
  } pdc_entry_t;

  // offset of the last byte of each header field
  function automatic logic [6:0] fld_end(input logic [3:0] f);
    logic [6:0] e;
    unique case (f)
      4'd0:    e = 7'd1;
      4'd1:    e = 7'd5;
      4'd2:    e = 7'd13;
      4'd3:    e = 7'd21;
      4'd4:    e = 7'd25;
      4'd5:    e = 7'd33;
      4'd6:    e = 7'd41;
      4'd7:    e = 7'd49;
      4'd8:    e = 7'd57;
      4'd9:    e = 7'd65;
      4'd10:   e = 7'd73;
      4'd11:   e = 7'd81;
      default: e = 7'd85;
    endcase
    return e;
  endfunction

  // byte width of each header field
  function automatic logic [3:0] fld_len(input logic [3:0] f);
    logic [3:0] n;
    unique case (f)
      4'd0:                  n = 4'd2;
      4'd1, 4'd4, 4'd12:     n = 4'd4;
      default:               n = 4'd8;
    endcase
    return n;
  endfunction

  // header field that a header byte offset falls in
  function automatic logic [3:0] field_of(input logic [6:0] pos);
    logic [3:0] idx;
    idx = 4'(NUM_FIELDS - 1);
    for (int i = NUM_FIELDS - 2; i >= 0; i--) begin
      if (pos <= fld_end(4'(i))) idx = 4'(i);
    end
    return idx;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ----- rtl/pdc_ifs.sv -----
// Channel interfaces of the packet deframer/checker: byte input, result
// output and config write. Depends on pdc_pkg.
interface pdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       final_byte;
  modport source (output valid, rx_byte, final_byte, input ready);
  modport sink   (input valid, rx_byte, final_byte, output ready);
endinterface

interface pdc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  field_index;
  logic [63:0] value;
  logic [2:0]  status;
  logic        done_res;
  modport source (output valid, kind, field_index, value, status, done_res, input ready);
  modport sink   (input valid, kind, field_index, value, status, done_res, output ready);
endinterface

interface pdc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pdc_pkg::CFG_IDX_W-1:0]  index;
  logic [15:0]                    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/pdc_front.sv -----
// Front end: byte counter, header field assembly and byte classification.
// Depends on pdc_pkg and pdc_ifs; feeds pdc_fifo.
module pdc_front #(
  parameter int COUNT_BITS = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  pdc_in_if.sink              in_ch,
  input  logic [15:0]         expected_version,
  input  logic                q_full,
  output logic                push,
  output pdc_pkg::pdc_entry_t push_entry
);
  import pdc_pkg::*;

  localparam int WIDE = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 2;

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [63:0]           fs_r, fs_nxt;
  logic [31:0]           atom_r, atom_nxt;
  logic [31:0]           dp_r, dp_nxt;
  logic                  vbad_r, vbad_nxt;

  logic [7:0]      b;
  logic            fin;
  logic            in_hdr;
  logic [3:0]      fidx;
  logic            fdone;
  logic [63:0]     fs_shift;
  logic [63:0]     fval;
  logic [WIDE-1:0] posw, pay_end, trl_end, len_expect;
  logic            is_pay, is_trl;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign fin         = in_ch.final_byte;

  always_comb begin
    cnt_nxt  = (cnt_r == {COUNT_BITS{1'b1}}) ? cnt_r : cnt_r + 1'b1;
    in_hdr   = cnt_r < COUNT_BITS'(HDR_BYTES);
    fidx     = field_of(cnt_r[6:0]);
    fdone    = in_hdr && (cnt_r[6:0] == fld_end(fidx));
    // version is big-endian, the rest little-endian
    fs_shift = (fidx == FLD_VERSION) ? {fs_r[55:0], b} : {b, fs_r[63:8]};

    if (fidx == FLD_VERSION) begin
      fval = {48'd0, fs_shift[15:0]};
    end else if (fld_len(fidx) == 4'd4) begin
      fval = {32'd0, fs_shift[63:32]};
    end else begin
      fval = fs_shift;
    end

    posw    = WIDE'(cnt_r);
    pay_end = WIDE'(dp_r) + WIDE'(HDR_BYTES);
    trl_end = WIDE'(dp_r) + WIDE'(HDR_BYTES + TRAILER_BYTES);
    is_pay  = !in_hdr && (posw < pay_end);
    is_trl  = !in_hdr && !is_pay && (posw < trl_end);

    atom_nxt = (fdone && fidx == FLD_ATOMS)   ? fval[31:0] : atom_r;
    dp_nxt   = (fdone && fidx == FLD_PAYLOAD) ? fval[31:0] : dp_r;
    vbad_nxt = (fdone && fidx == FLD_VERSION) ? (fval[15:0] != expected_version) : vbad_r;

    if (fdone) begin
      fs_nxt = '0;
    end else if (in_hdr) begin
      fs_nxt = fs_shift;
    end else begin
      fs_nxt = fs_r;
    end

    len_expect = WIDE'(dp_nxt) + WIDE'(HDR_BYTES + TRAILER_BYTES);

    push_entry.data      = b;
    push_entry.fin       = fin;
    push_entry.crc_en    = in_hdr || is_pay;
    push_entry.trl_en    = is_trl;
    push_entry.emit      = fdone || is_pay;
    push_entry.kind      = fdone ? KIND_FIELD : KIND_PAYLOAD;
    push_entry.field_idx = fdone ? fidx : 4'd0;
    if (fin) begin
      push_entry.value = {atom_nxt, dp_nxt};
    end else if (fdone) begin
      push_entry.value = fval;
    end else begin
      push_entry.value = {56'd0, b};
    end
    push_entry.short_pkt = cnt_nxt < COUNT_BITS'(HDR_BYTES + TRAILER_BYTES);
    push_entry.ver_bad   = vbad_nxt;
    push_entry.len_bad   = WIDE'(cnt_nxt) != len_expect;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      fs_r   <= '0;
      atom_r <= '0;
      dp_r   <= '0;
      vbad_r <= 1'b0;
    end else if (push) begin
      if (fin) begin
        cnt_r  <= '0;
        fs_r   <= '0;
        atom_r <= '0;
        dp_r   <= '0;
        vbad_r <= 1'b0;
      end else begin
        cnt_r  <= cnt_nxt;
        fs_r   <= fs_nxt;
        atom_r <= atom_nxt;
        dp_r   <= dp_nxt;
        vbad_r <= vbad_nxt;
      end
    end
  end

endmodule

// ----- rtl/pdc_fifo.sv -----
// Short queue of classified items between front and back end.
// Depends on pdc_pkg.
module pdc_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pdc_pkg::pdc_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                q_valid,
  output pdc_pkg::pdc_entry_t q_entry
);
  import pdc_pkg::*;

  pdc_entry_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign full    = cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign q_valid = cnt_r != '0;
  assign q_entry = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- rtl/pdc_back.sv -----
// Back end: running CRC, trailer capture, final checks and result register.
// Depends on pdc_pkg and pdc_ifs; drains pdc_fifo.
module pdc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  pdc_pkg::pdc_entry_t q_entry,
  output logic                pop,
  input  logic [15:0]         record_bytes,
  pdc_out_if.source           out_ch
);
  import pdc_pkg::*;

  logic [31:0] crc_r, crc_nxt;
  logic [31:0] trl_r, trl_nxt;
  logic [47:0] expect_size;
  logic [2:0]  st;

  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [3:0]  idx_r;
  logic [63:0] value_r;
  logic [2:0]  status_r;
  logic        done_r;

  assign pop = q_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    crc_nxt     = q_entry.crc_en ? crc_byte(crc_r, q_entry.data) : crc_r;
    trl_nxt     = q_entry.trl_en ? {q_entry.data, trl_r[31:8]} : trl_r;
    expect_size = 48'(q_entry.value[63:32]) * 48'(record_bytes);
    if (q_entry.short_pkt) begin
      st = ST_SHORT;
    end else if (q_entry.ver_bad) begin
      st = ST_VERSION;
    end else if (expect_size != {16'd0, q_entry.value[31:0]}) begin
      st = ST_PAYLOAD;
    end else if (q_entry.len_bad) begin
      st = ST_LENGTH;
    end else if (~crc_nxt != trl_nxt) begin
      st = ST_CRC;
    end else begin
      st = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      trl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        if (q_entry.fin) begin
          crc_r       <= CRC_INIT;
          trl_r       <= '0;
          out_valid_r <= 1'b1;
        end else begin
          crc_r       <= crc_nxt;
          trl_r       <= trl_nxt;
          out_valid_r <= q_entry.emit;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (q_entry.fin) begin
        kind_r   <= KIND_STATUS;
        idx_r    <= 4'd0;
        value_r  <= '0;
        status_r <= st;
        done_r   <= 1'b1;
      end else begin
        kind_r   <= q_entry.kind;
        idx_r    <= q_entry.field_idx;
        value_r  <= q_entry.value;
        status_r <= ST_OK;
        done_r   <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.field_index = idx_r;
  assign out_ch.value       = value_r;
  assign out_ch.status      = status_r;
  assign out_ch.done_res    = done_r;

endmodule

// ----- rtl/packet_deframer_checker.sv -----
// Top level of the packet deframer/checker.
// Depends on pdc_pkg, pdc_ifs, pdc_front, pdc_fifo and pdc_back.
//
// Takes a received packet one byte per item on in_ch, final_byte set on the
// last byte. The first 86 bytes are the header (big-endian 16-bit version,
// then twelve little-endian fields); each of the 13 fields comes out as a
// kind-1 result when its last byte arrives, payload bytes come out as kind-0
// results, and the last byte yields only a single kind-2 status result with
// done_res set (0 ok, 1 short, 2 version, 3 payload size, 4 length, 5 crc,
// first failing check wins). On a nonzero status the emitted fields and
// payload must be thrown away downstream. A reflected CRC-32 runs over header
// and payload and is compared with the 4-byte little-endian trailer; bytes
// after the trailer are dropped and show up as a length error. The byte
// counter is COUNT_BITS wide and saturates. Throughput is one item per clock
// while the receiver keeps out_ch ready: the front end classifies a byte in
// the cycle it is accepted, a 4-entry queue decouples it from the back end
// (a full queue stalls in_ch), and the back end runs one CRC byte step and
// the atom-count times record-size product per cycle into an output register.
// An accepted item is written into the queue and then loaded into the output
// register that drives the result. cfg_ch is always ready; write it only
// while the block is idle.
module packet_deframer_checker #(
  parameter int COUNT_BITS = 40
) (
  input  logic       clk,
  input  logic       rst_n,
  pdc_in_if.sink     in_ch,
  pdc_out_if.source  out_ch,
  pdc_cfg_if.sink    cfg_ch
);
  import pdc_pkg::*;

  // config registers
  logic [15:0] expected_version_r;
  logic [15:0] record_bytes_r;

  // front -> queue -> back
  logic       push, q_full, pop, q_valid;
  pdc_entry_t push_entry, q_entry;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_version_r <= 16'd1;
      record_bytes_r     <= 16'd64;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_EXP_VERSION:  expected_version_r <= cfg_ch.data;
        CFG_RECORD_BYTES: record_bytes_r     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // classification and header assembly
  pdc_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_ch),
    .expected_version (expected_version_r),
    .q_full           (q_full),
    .push             (push),
    .push_entry       (push_entry)
  );

  pdc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  // CRC, trailer and final status
  pdc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .pop          (pop),
    .record_bytes (record_bytes_r),
    .out_ch       (out_ch)
  );

endmodule

// ----- tb/tb_packet_deframer_checker.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for packet_deframer_checker: builds frames, drives them through
// the byte, result and config channels and checks every result against a built-in predictor.
// Depends on pdc_pkg, pdc_ifs and the packet_deframer_checker RTL.
module tb_packet_deframer_checker;
  import pdc_pkg::*;

  // Narrower counter than the block default.
  localparam int COUNT_BITS  = 16;
  localparam logic [63:0] CNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
  localparam int ATOMS_AT    = 22;   // first byte of the atom count field
  localparam int PSIZE_AT    = 82;   // first byte of the payload size field
  localparam int STALL_LIMIT = 2000; // cycles with no handshake at all
  localparam int HOLD_CYCLES = 300;
  localparam int SEG_BYTES   = 50;
  localparam int PREDICTED   = -1;   // final status comes from the predictor

  // last byte offset and byte width of each header field, index 0 on the right
  localparam logic [NUM_FIELDS-1:0][6:0] FIELD_LAST = {
    7'd85, 7'd81, 7'd73, 7'd65, 7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd21, 7'd13, 7'd5, 7'd1};
  localparam logic [NUM_FIELDS-1:0][3:0] FIELD_WIDTH = {
    4'd4, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd4, 4'd8, 4'd8, 4'd4, 4'd2};

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  field_index;
    logic [63:0] value;
    logic [2:0]  status;
    logic        done_res;
  } deframe_result_t;

  typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RAND} fill_t;

  // One directed frame: header values, payload length actually sent, header/payload
  // filler, trailer good or corrupted, bytes after the trailer, truncation point.
  typedef struct packed {
    logic [15:0] version;
    logic [31:0] atoms;
    logic [31:0] psize;
    int          body_len;
    fill_t       fill;
    bit          crc_good;
    int          extra;
    int          cut;          // 0: whole frame, else frame ends after this many bytes
    int          want_status;
  } frame_row_t;

  // Directed frames, all under the reset config (version 1, 64 bytes per record).
  frame_row_t dir_rows [17] = '{
    // single 0xFF byte marked final
    '{16'hFFFF, 32'd0, 32'd0, 0, FILL_ONES, 1'b1, 0, 1, ST_SHORT},
    // smallest good frame, zero header apart from version 1
    '{16'h0001, 32'd0, 32'd0, 0, FILL_ZERO, 1'b1, 0, 0, ST_OK},
    // one record, every other header and payload byte 0xFF
    '{16'h0001, 32'd1, 32'd64, 64, FILL_ONES, 1'b1, 0, 0, ST_OK},
    '{16'h0000, 32'd0, 32'd0, 0, FILL_RAND, 1'b1, 0, 0, ST_VERSION},
    '{16'h0001, 32'd2, 32'd64, 0, FILL_RAND, 1'b1, 0, 0, ST_PAYLOAD},
    // bytes after the trailer are dropped but counted
    '{16'h0001, 32'd0, 32'd0, 0, FILL_RAND, 1'b1, 3, 0, ST_LENGTH},
    '{16'h0001, 32'd0, 32'd0, 0, FILL_RAND, 1'b0, 0, 0, ST_CRC},
    // one byte short of the minimum length
    '{16'h0001, 32'd0, 32'd0, 0, FILL_RAND, 1'b1, 0, 89, ST_SHORT},
    // final flag on the byte that completes the last header field
    '{16'h0001, 32'd0, 32'd0, 0, FILL_ONES, 1'b1, 0, 86, ST_SHORT},
    // final flag on the byte that completes the version field
    '{16'h0001, 32'd0, 32'd0, 0, FILL_RAND, 1'b1, 0, 2, ST_SHORT},
    // final flag on a payload byte
    '{16'h0001, 32'd1, 32'd64, 64, FILL_RAND, 1'b1, 0, 100, ST_LENGTH},
    // payload one byte short: first trailer byte is taken as payload
    '{16'h0001, 32'd0, 32'd8, 7, FILL_RAND, 1'b1, 0, 0, PREDICTED},
    // check order: version beats payload size and crc
    '{16'h0002, 32'd3, 32'd64, 0, FILL_RAND, 1'b0, 0, 0, ST_VERSION},
    // payload size beats length and crc
    '{16'h0001, 32'd3, 32'd64, 0, FILL_RAND, 1'b0, 2, 0, ST_PAYLOAD},
    // length beats crc
    '{16'h0001, 32'd0, 32'd0, 0, FILL_RAND, 1'b0, 1, 0, ST_LENGTH},
    // all-ones header: huge declared payload swallows the trailer
    '{16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4, FILL_ONES, 1'b1, 0, 0, ST_VERSION},
    // a good frame right after all the broken ones
    '{16'h0001, 32'd1, 32'd64, 64, FILL_ZERO, 1'b1, 0, 0, ST_OK}
  };

  logic clk;
  logic rst_n;

  pdc_in_if  in_ch ();
  pdc_out_if out_ch ();
  pdc_cfg_if cfg_ch ();

  packet_deframer_checker #(
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the config and of the per-frame registers.
  // ---------------------------------------------------------------------------
  logic [15:0] reg_version = 16'd1;
  logic [15:0] reg_record  = 16'd64;
  logic [63:0] frm_count   = '0;
  logic [63:0] frm_shift   = '0;
  logic [31:0] frm_crc     = 32'hFFFF_FFFF;
  logic [31:0] frm_atoms   = '0;
  logic [31:0] frm_payload = '0;
  logic [31:0] frm_trailer = '0;
  logic        frm_ver_bad = 1'b0;

  deframe_result_t pending_results[$];  // expected results, oldest first
  int              typed_status_q[$];   // one per frame: table status or PREDICTED
  logic [7:0]      frame_q[$];          // bytes of the frame being sent

  int          err_count = 0;
  int          quiet_cycles = 0;
  int          bytes_sent = 0;
  int          in_idle_pct = 33;
  int          out_idle_pct = 61;
  int          hold_req = 0;
  logic [15:0] gen_version = 16'd1;  // config the generator builds frames for
  logic [15:0] gen_record  = 16'd64;

  // Reflected CRC-32, one data bit at a time.
  function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  // One received byte through the predictor; pushes the result it causes, if any.
  task automatic deframe_step(input logic [7:0] b, input logic fin);
    logic [63:0]     pos;
    logic [63:0]     len;
    logic [63:0]     off;
    logic [63:0]     v;
    logic [63:0]     want;
    logic [2:0]      st;
    int              f;
    bit              emit;
    deframe_result_t r;
    pos  = frm_count;
    emit = 1'b0;
    r    = '0;
    if (frm_count < CNT_MAX) frm_count = frm_count + 64'd1;
    len = frm_count;

    if (pos < HDR_BYTES) begin
      frm_crc = crc32_update(frm_crc, b);
      f = 0;
      while (f < NUM_FIELDS - 1 && pos > FIELD_LAST[f]) f++;
      // version is big-endian, every later field little-endian
      if (f == FLD_VERSION) frm_shift = {frm_shift[55:0], b};
      else                  frm_shift = {b, frm_shift[63:8]};
      if (pos == FIELD_LAST[f]) begin
        if (f == FLD_VERSION) begin
          v = {48'd0, frm_shift[15:0]};
          frm_ver_bad = (frm_shift[15:0] != reg_version);
        end else begin
          v = frm_shift >> (64 - 8 * FIELD_WIDTH[f]);
        end
        if (f == FLD_ATOMS)   frm_atoms   = v[31:0];
        if (f == FLD_PAYLOAD) frm_payload = v[31:0];
        frm_shift = '0;
        r = '{KIND_FIELD, 4'(f), v, ST_OK, 1'b0};
        emit = 1'b1;
      end
    end else begin
      off = pos - HDR_BYTES;
      if (off < {32'd0, frm_payload}) begin
        frm_crc = crc32_update(frm_crc, b);
        r = '{KIND_PAYLOAD, 4'd0, {56'd0, b}, ST_OK, 1'b0};
        emit = 1'b1;
      end else if (off - {32'd0, frm_payload} < TRAILER_BYTES) begin
        frm_trailer = {b, frm_trailer[31:8]};
      end
    end

    // final byte: only the status comes out, first failing check wins
    if (fin) begin
      want = {32'd0, frm_atoms} * {48'd0, reg_record};
      if (len < HDR_BYTES + TRAILER_BYTES)                   st = ST_SHORT;
      else if (frm_ver_bad)                                   st = ST_VERSION;
      else if (want != {32'd0, frm_payload})                  st = ST_PAYLOAD;
      else if (len != 64'(HDR_BYTES + TRAILER_BYTES) + {32'd0, frm_payload})
                                                              st = ST_LENGTH;
      else if (~frm_crc != frm_trailer)                       st = ST_CRC;
      else                                                    st = ST_OK;
      r = '{KIND_STATUS, 4'd0, 64'd0, st, 1'b1};
      emit = 1'b1;
      frm_count   = '0;
      frm_shift   = '0;
      frm_crc     = 32'hFFFF_FFFF;
      frm_atoms   = '0;
      frm_payload = '0;
      frm_trailer = '0;
      frm_ver_bad = 1'b0;
    end
    if (emit) pending_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_count++;
    $display("%0t: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: config writes and accepted bytes feed the predictor, accepted
  // results are checked against the oldest expectation. All sampled at the edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    deframe_result_t got;
    deframe_result_t want;
    int              typed;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_EXP_VERSION) reg_version = cfg_ch.data;
        else                                 reg_record  = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        deframe_step(in_ch.rx_byte, in_ch.final_byte);
        if (in_ch.final_byte && typed_status_q.size() != 0) begin
          typed = typed_status_q.pop_front();
          if (typed != PREDICTED) pending_results[$].status = 3'(typed);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.kind, out_ch.field_index, out_ch.value, out_ch.status,
                out_ch.done_res};
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(got), 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (got.kind != want.kind)
            report_mismatch("kind", 64'(got.kind), 64'(want.kind));
          if (got.field_index != want.field_index)
            report_mismatch("field_index", 64'(got.field_index), 64'(want.field_index));
          if (got.value != want.value)
            report_mismatch("value", got.value, want.value);
          if (got.status != want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.done_res != want.done_res)
            report_mismatch("done_res", 64'(got.done_res), 64'(want.done_res));
        end
      end
    end
  end

  // Watchdog: any cycle without a handshake on any channel counts toward the limit.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("packet_deframer_checker verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result receiver: random back-pressure, plus a long hold-off on request.
  initial begin
    int hold;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold     = hold_req;
        hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] filler(input fill_t f);
    case (f)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      default:   return 8'($urandom);
    endcase
  endfunction

  // Builds header, payload, trailer and trailing junk into frame_q, then cuts it at cut.
  function automatic void build_frame(input logic [15:0] ver, input logic [31:0] atoms,
                                      input logic [31:0] psize, input int body_len,
                                      input fill_t fill, input bit crc_good,
                                      input int extra, input int cut);
    logic [31:0] crc;
    frame_q = {};
    for (int i = 0; i < HDR_BYTES; i++) frame_q.push_back(filler(fill));
    frame_q[0] = ver[15:8];
    frame_q[1] = ver[7:0];
    for (int k = 0; k < 4; k++) begin
      frame_q[ATOMS_AT + k] = atoms[8*k +: 8];
      frame_q[PSIZE_AT + k] = psize[8*k +: 8];
    end
    for (int i = 0; i < body_len; i++) frame_q.push_back(filler(fill));
    crc = 32'hFFFF_FFFF;
    foreach (frame_q[i]) crc = crc32_update(crc, frame_q[i]);
    crc = ~crc;
    if (!crc_good) crc = crc ^ (32'd1 << $urandom_range(31));
    for (int k = 0; k < TRAILER_BYTES; k++) frame_q.push_back(crc[8*k +: 8]);
    repeat (extra) frame_q.push_back(8'($urandom));
    if (cut > 0)
      while (frame_q.size() > cut) void'(frame_q.pop_back());
  endfunction

  // Offers one byte, with random idle cycles first; returns at the accepting edge.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.rx_byte    <= b;
    in_ch.final_byte <= fin;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input int want_status);
    typed_status_q.push_back(want_status);
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Stops the byte stream and waits until every expected result is in, then lets
  // bytes still in flight that cause no result drain.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] ver, input logic [15:0] rec);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_EXP_VERSION;
    cfg_ch.data  <= ver;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= CFG_RECORD_BYTES;
    cfg_ch.data  <= rec;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    gen_version = ver;
    gen_record  = rec;
  endtask

  // Mostly well-formed frames for the current config, then broken frames,
  // frames with random counts and sizes, and plain noise.
  task automatic make_random_frame();
    int          pick;
    int          body;
    int          extra;
    int          cut;
    int          n;
    bit          good;
    logic [15:0] ver;
    logic [31:0] atoms;
    logic [31:0] psize;
    pick  = $urandom_range(99);
    ver   = gen_version;
    good  = 1'b1;
    extra = 0;
    cut   = 0;
    if (gen_record == 0) begin
      atoms = $urandom;
      psize = 32'd0;
    end else begin
      atoms = $urandom_range(48 / gen_record, 0);
      psize = atoms * gen_record;
    end
    body = psize;
    if (pick >= 70 && pick < 80) begin
      case ($urandom_range(3))
        0:       ver   = ver ^ (16'd1 << $urandom_range(15));
        1:       good  = 1'b0;
        2:       extra = $urandom_range(6, 1);
        default: cut   = $urandom_range(HDR_BYTES + body + TRAILER_BYTES - 1, 1);
      endcase
    end else if (pick >= 80 && pick < 90) begin
      atoms = $urandom;
      psize = $urandom_range(1) ? 32'($urandom) : 32'($urandom_range(40));
      body  = $urandom_range(40);
      good  = $urandom_range(1);
    end
    build_frame(ver, atoms, psize, body, FILL_RAND, good, extra, cut);
    if (pick >= 90) begin
      frame_q = {};
      n = $urandom_range(120, 1);
      repeat (n) frame_q.push_back(8'($urandom));
    end
  endtask

  task automatic random_traffic(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      make_random_frame();
      send_frame(PREDICTED);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.rx_byte    <= 8'd0;
    in_ch.final_byte <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_EXP_VERSION;
    cfg_ch.data      <= 16'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames under the reset config, sender 33% idle, receiver 61%
    foreach (dir_rows[i]) begin
      build_frame(dir_rows[i].version, dir_rows[i].atoms, dir_rows[i].psize,
                  dir_rows[i].body_len, dir_rows[i].fill, dir_rows[i].crc_good,
                  dir_rows[i].extra, dir_rows[i].cut);
      send_frame(dir_rows[i].want_status);
    end

    // random segments; config extremes first, then the idle pattern swaps, then no idling
    write_config(16'hFFFF, 16'd0);           // zero record size: product is zero
    random_traffic(SEG_BYTES);
    write_config(16'h0000, 16'hFFFF);
    random_traffic(SEG_BYTES);

    in_idle_pct  = 61;
    out_idle_pct = 33;
    write_config(16'($urandom), 16'($urandom_range(8, 1)));
    random_traffic(SEG_BYTES);
    write_config(16'($urandom), 16'd1);
    random_traffic(SEG_BYTES);

    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_config(16'($urandom), 16'($urandom_range(16, 2)));
    // receiver stops for a long stretch while bytes keep coming: the queue
    // fills and the input must stall
    hold_req = HOLD_CYCLES;
    random_traffic(SEG_BYTES);
    write_config(16'd1, 16'd64);
    random_traffic(SEG_BYTES);

    wait_idle();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("packet_deframer_checker verification clean");
    end else begin
      $display("packet_deframer_checker verification failed");
    end
    $finish;
  end

endmodule
